[rtl/core/qfp_pkg.sv]
// shared constants for the quicksort first-pivot sorter
package qfp_pkg;

	// store size and derived widths
	localparam int MAX_ELEMENTS = 64;
	localparam int DATA_W       = 32;
	localparam int IDX_W        = $clog2(MAX_ELEMENTS);
	localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
	localparam int ENTRY_W      = 2 * IDX_W;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMENTS);

endpackage

[rtl/core/qfp_ram.sv]
// generic single write, single registered read memory
module qfp_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/quicksort_first_pivot.sv]
// Sorter: loads signed 32-bit values until one is flagged tlast, sorts them by quicksort
// with the first element of each range as pivot, then streams them out in ascending order
// with tlast on the final value. Up to 64 values are kept; values beyond that are dropped,
// but a dropped value flagged tlast still starts the sort. Loading accepts one value per
// cycle. The sort runs through an element memory with one write port and one registered
// read port: each range is popped and its pivot read, the scans compare and swap values,
// then the pivot is placed and the sub-ranges are pushed. Already sorted input is the worst
// case. Each output value is read from memory and then held until the sink takes it. No
// input is taken while sorting or sending.
module quicksort_first_pivot (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [qfp_pkg::DATA_W-1:0]  s_axis_tdata,   // [31:0] value
	input  logic                        s_axis_tlast,   // final_item
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [qfp_pkg::DATA_W-1:0]  m_axis_tdata,   // [31:0] sorted_value
	output logic                        m_axis_tlast    // end_of_run
);

	import qfp_pkg::*;

	// sequencer states
	localparam logic [3:0] S_LOAD   = 4'd0;
	localparam logic [3:0] S_START  = 4'd1;
	localparam logic [3:0] S_POP    = 4'd2;
	localparam logic [3:0] S_POPW   = 4'd3;
	localparam logic [3:0] S_PIVW   = 4'd4;
	localparam logic [3:0] S_SCANI  = 4'd5;
	localparam logic [3:0] S_SCANIW = 4'd6;
	localparam logic [3:0] S_SCANJ  = 4'd7;
	localparam logic [3:0] S_SCANJW = 4'd8;
	localparam logic [3:0] S_CHK    = 4'd9;
	localparam logic [3:0] S_SWAP2  = 4'd10;
	localparam logic [3:0] S_FIN2   = 4'd11;
	localparam logic [3:0] S_PUSH2  = 4'd12;
	localparam logic [3:0] S_ORD    = 4'd13;
	localparam logic [3:0] S_OSHOW  = 4'd14;

	logic [3:0]        state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  depth_q;
	logic [CNT_W-1:0]  lo_q;
	logic [CNT_W-1:0]  hi_q;
	logic [CNT_W-1:0]  i_q;
	logic [CNT_W-1:0]  j_q;
	logic [CNT_W-1:0]  k_q;
	logic [DATA_W-1:0] pk_q;
	logic [DATA_W-1:0] vi_q;
	logic [DATA_W-1:0] vj_q;

	// element memory port
	logic              e_we;
	logic [IDX_W-1:0]  e_waddr;
	logic [DATA_W-1:0] e_wdata;
	logic              e_re;
	logic [IDX_W-1:0]  e_raddr;
	logic [DATA_W-1:0] e_rdata;

	// range stack port
	logic               r_we;
	logic [IDX_W-1:0]   r_waddr;
	logic [ENTRY_W-1:0] r_wdata;
	logic               r_re;
	logic [IDX_W-1:0]   r_raddr;
	logic [ENTRY_W-1:0] r_rdata;

	logic              in_acc;
	logic              out_acc;
	logic [CNT_W-1:0]  pop_lo;
	logic [CNT_W-1:0]  pop_hi;
	logic [CNT_W-1:0]  p_inc;
	logic [CNT_W-1:0]  p_dec;
	logic [CNT_W-1:0]  n_dec;
	logic [CNT_W-1:0]  depth_dec;
	logic              push_hi_ok;
	logic              push_lo_ok;
	logic              rd_le_pk;

	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign out_acc   = m_axis_tvalid && m_axis_tready;
	assign pop_lo    = CNT_W'(r_rdata[ENTRY_W-1:IDX_W]);
	assign pop_hi    = CNT_W'(r_rdata[IDX_W-1:0]);
	assign p_inc     = j_q + 1'b1;
	assign p_dec     = j_q - 1'b1;
	assign n_dec     = count_q - 1'b1;
	assign depth_dec = depth_q - 1'b1;
	assign rd_le_pk  = $signed(e_rdata) <= $signed(pk_q);

	// only ranges of two or more are pushed, and never into a full stack
	assign push_hi_ok = (p_inc < hi_q) && (depth_q < MAX_CNT);
	assign push_lo_ok = (j_q > lo_q) && (lo_q < p_dec) && (depth_q < MAX_CNT);

	assign s_axis_tready = (state_q == S_LOAD);
	assign m_axis_tvalid = (state_q == S_OSHOW);
	assign m_axis_tdata  = e_rdata;
	assign m_axis_tlast  = ((k_q + 1'b1) == count_q);

	qfp_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MAX_ELEMENTS)
	) u_elem (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.re    (e_re),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	qfp_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_ELEMENTS)
	) u_stack (
		.clk   (clk),
		.we    (r_we),
		.waddr (r_waddr),
		.wdata (r_wdata),
		.re    (r_re),
		.raddr (r_raddr),
		.rdata (r_rdata)
	);

	// memory port control per state
	always_comb begin
		e_we    = 1'b0;
		e_waddr = '0;
		e_wdata = '0;
		e_re    = 1'b0;
		e_raddr = '0;
		r_we    = 1'b0;
		r_waddr = '0;
		r_wdata = '0;
		r_re    = 1'b0;
		r_raddr = '0;
		case (state_q)
			S_LOAD: begin
				if (in_acc && (count_q < MAX_CNT)) begin
					e_we    = 1'b1;
					e_waddr = count_q[IDX_W-1:0];
					e_wdata = s_axis_tdata;
				end
			end
			S_START: begin
				r_we    = (count_q > CNT_W'(1));
				r_waddr = '0;
				r_wdata = {IDX_W'(0), n_dec[IDX_W-1:0]};
			end
			S_POP: begin
				r_re    = (depth_q != '0);
				r_raddr = depth_dec[IDX_W-1:0];
			end
			S_POPW: begin
				e_re    = (pop_lo < pop_hi);
				e_raddr = pop_lo[IDX_W-1:0];
			end
			S_SCANI: begin
				e_re    = (i_q <= hi_q);
				e_raddr = i_q[IDX_W-1:0];
			end
			S_SCANJ: begin
				e_re    = (j_q > lo_q);
				e_raddr = j_q[IDX_W-1:0];
			end
			S_CHK: begin
				// swap first half, or move the j value into the pivot slot
				e_we    = 1'b1;
				e_wdata = vj_q;
				e_waddr = (i_q < j_q) ? i_q[IDX_W-1:0] : lo_q[IDX_W-1:0];
			end
			S_SWAP2: begin
				e_we    = 1'b1;
				e_waddr = j_q[IDX_W-1:0];
				e_wdata = vi_q;
			end
			S_FIN2: begin
				e_we    = 1'b1;
				e_waddr = j_q[IDX_W-1:0];
				e_wdata = pk_q;
				r_we    = push_hi_ok;
				r_waddr = depth_q[IDX_W-1:0];
				r_wdata = {p_inc[IDX_W-1:0], hi_q[IDX_W-1:0]};
			end
			S_PUSH2: begin
				r_we    = push_lo_ok;
				r_waddr = depth_q[IDX_W-1:0];
				r_wdata = {lo_q[IDX_W-1:0], p_dec[IDX_W-1:0]};
			end
			S_ORD: begin
				e_re    = 1'b1;
				e_raddr = k_q[IDX_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// working values of the partition scans
	always_ff @(posedge clk) begin
		case (state_q)
			S_PIVW: begin
				pk_q <= e_rdata;
			end
			S_SCANIW: begin
				vi_q <= e_rdata;
			end
			S_SCANJ: begin
				if (j_q <= lo_q) begin
					vj_q <= pk_q;
				end
			end
			S_SCANJW: begin
				vj_q <= e_rdata;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			count_q <= '0;
			depth_q <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (count_q < MAX_CNT) begin
							count_q <= count_q + 1'b1;
						end
						if (s_axis_tlast) begin
							state_q <= S_START;
						end
					end
				end
				S_START: begin
					depth_q <= (count_q > CNT_W'(1)) ? CNT_W'(1) : '0;
					state_q <= S_POP;
				end
				S_POP: begin
					if (depth_q == '0) begin
						k_q     <= '0;
						state_q <= S_ORD;
					end else begin
						depth_q <= depth_dec;
						state_q <= S_POPW;
					end
				end
				S_POPW: begin
					lo_q    <= pop_lo;
					hi_q    <= pop_hi;
					i_q     <= pop_lo;
					j_q     <= pop_hi;
					state_q <= (pop_lo < pop_hi) ? S_PIVW : S_POP;
				end
				S_PIVW: begin
					state_q <= S_SCANI;
				end
				S_SCANI: begin
					state_q <= (i_q <= hi_q) ? S_SCANIW : S_SCANJ;
				end
				S_SCANIW: begin
					if (rd_le_pk) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_SCANI;
					end else begin
						state_q <= S_SCANJ;
					end
				end
				S_SCANJ: begin
					state_q <= (j_q > lo_q) ? S_SCANJW : S_CHK;
				end
				S_SCANJW: begin
					if (!rd_le_pk) begin
						j_q     <= j_q - 1'b1;
						state_q <= S_SCANJ;
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					state_q <= (i_q < j_q) ? S_SWAP2 : S_FIN2;
				end
				S_SWAP2: begin
					state_q <= S_SCANI;
				end
				S_FIN2: begin
					if (push_hi_ok) begin
						depth_q <= depth_q + 1'b1;
					end
					state_q <= S_PUSH2;
				end
				S_PUSH2: begin
					if (push_lo_ok) begin
						depth_q <= depth_q + 1'b1;
					end
					state_q <= S_POP;
				end
				S_ORD: begin
					state_q <= S_OSHOW;
				end
				S_OSHOW: begin
					if (out_acc) begin
						if (m_axis_tlast) begin
							count_q <= '0;
							depth_q <= '0;
							state_q <= S_LOAD;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_ORD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// stack never grows past the store size
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= MAX_CNT)
		else $error("range stack depth out of bounds");

	// scans stay inside the range being partitioned
	a_scan_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCANI) |-> ((i_q <= (hi_q + 1'b1)) && (j_q >= lo_q) && (j_q <= hi_q)))
		else $error("partition scan left its range");

	// output index stays below the element count
	a_out_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (k_q < count_q))
		else $error("output index past element count");

	// after the final request the block returns to loading
	a_back_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && m_axis_tlast) |=> (s_axis_tready && !m_axis_tvalid && (count_q == '0)))
		else $error("block did not return to loading after final value");

endmodule

[tb/sv/tb_quicksort_first_pivot.sv]
// self-checking testbench for the quicksort first-pivot sorter
`timescale 1ns / 1ps

module tb_quicksort_first_pivot;

	import qfp_pkg::*;

	localparam int ITEM_TARGET  = 410;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 200;
	localparam int REPORT_MAX   = 10;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              eor;
	} sorted_word_t;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata;
	logic              s_axis_tlast;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [DATA_W-1:0] m_axis_tdata;
	logic              m_axis_tlast;

	// values of the set being loaded, and the sorted words still owed by the block
	logic signed [DATA_W-1:0] loading_set[$];
	sorted_word_t             owed_words[$];

	int  values_stored;
	int  values_dropped;
	int  runs_closed;
	int  words_checked;
	int  mismatches;
	int  cycle_count;
	int  stall_left;
	bit  src_idle_en;
	bit  snk_stall_en;

	quicksort_first_pivot DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// cycle watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still owed",
				cycle_count, owed_words.size());
			$display("tb_quicksort_first_pivot: FAIL");
			$finish;
		end
	end

	// idle length: mostly short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return $urandom_range(1, 3);
		end else if (r < 92) begin
			return $urandom_range(4, 8);
		end
		return $urandom_range(12, 40);
	endfunction

	// random element: full range, small clustered, extremes, repeated
	function automatic logic [DATA_W-1:0] rand_value();
		case ($urandom_range(0, 4))
			0, 1: begin
				return $urandom;
			end
			2: begin
				return 32'($urandom_range(0, 15)) - 32'd8;
			end
			3: begin
				case ($urandom_range(0, 5))
					0:       return 32'h8000_0000;
					1:       return 32'h7FFF_FFFF;
					2:       return 32'h0000_0000;
					3:       return 32'hFFFF_FFFF;
					4:       return 32'h8000_0001;
					default: return 32'h7FFF_FFFE;
				endcase
			end
			default: begin
				return 32'($urandom_range(0, 3)) * 32'd1000;
			end
		endcase
	endfunction

	// sink side: random stalls on tready
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (snk_stall_en && $urandom_range(0, 99) < 25) begin
			stall_left = pick_gap() - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// predictor: collect each set, emit it in ascending signed order on the closing request
	always @(posedge clk) begin : predict_sorted_run
		int                       i;
		int                       j;
		logic signed [DATA_W-1:0] key;
		sorted_word_t             w;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			if (loading_set.size() < MAX_ELEMENTS) begin
				loading_set.push_back(s_axis_tdata);
				values_stored++;
			end else begin
				values_dropped++;
			end
			if (s_axis_tlast) begin
				// insertion sort of the stored set
				for (i = 1; i < loading_set.size(); i++) begin
					key = loading_set[i];
					j = i;
					while (j > 0 && loading_set[j-1] > key) begin
						loading_set[j] = loading_set[j-1];
						j--;
					end
					loading_set[j] = key;
				end
				for (i = 0; i < loading_set.size(); i++) begin
					w.value = loading_set[i];
					w.eor   = (i == loading_set.size() - 1);
					owed_words.push_back(w);
				end
				loading_set.delete();
				runs_closed++;
			end
		end
	end

	// checker: each result against the oldest owed word
	always @(posedge clk) begin : check_sorted_word
		sorted_word_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (owed_words.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("unexpected result: value %0d last %b",
						$signed(m_axis_tdata), m_axis_tlast);
				end
			end else begin
				want = owed_words.pop_front();
				words_checked++;
				if (want.value !== m_axis_tdata || want.eor !== m_axis_tlast) begin
					mismatches++;
					if (mismatches <= REPORT_MAX) begin
						$display("mismatch at word %0d: expected %0d last %b, got %0d last %b",
							words_checked, $signed(want.value), want.eor,
							$signed(m_axis_tdata), m_axis_tlast);
					end
				end
			end
		end
	end

	// one request on the input side, called and returning at a falling edge
	task automatic send_item(input logic [DATA_W-1:0] v, input logic last);
		int gap;
		gap = (src_idle_en && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v;
		s_axis_tlast  <= last;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		@(negedge clk);
	endtask

	// hold off the sender until every owed word has come back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (owed_words.size() != 0) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// single-element sets at both extremes
	task automatic test_lone_value();
		send_item(32'h7FFF_FFFF, 1'b1);
		send_item(32'h8000_0000, 1'b1);
	endtask

	// field extremes with duplicates in one set
	task automatic test_field_extremes();
		send_item(32'h0000_0000, 1'b0);
		send_item(32'h7FFF_FFFF, 1'b0);
		send_item(32'h8000_0000, 1'b0);
		send_item(32'hFFFF_FFFF, 1'b0);
		send_item(32'h0000_0001, 1'b0);
		send_item(32'h7FFF_FFFF, 1'b0);
		send_item(32'h8000_0000, 1'b0);
		send_item(32'h0000_0000, 1'b1);
	endtask

	// ordered, reversed and constant sets
	task automatic test_ordered_inputs();
		send_item(-32'sd300, 1'b0);
		send_item(-32'sd2, 1'b0);
		send_item(32'sd0, 1'b0);
		send_item(32'sd5, 1'b0);
		send_item(32'sd70, 1'b0);
		send_item(32'sd1000, 1'b1);
		send_item(32'sd900, 1'b0);
		send_item(32'sd12, 1'b0);
		send_item(-32'sd1, 1'b0);
		send_item(-32'sd50, 1'b0);
		send_item(-32'sd6000, 1'b1);
		repeat (3) send_item(-32'sd7, 1'b0);
		send_item(-32'sd7, 1'b1);
	endtask

	// full store: extra requests dropped, one closing on a dropped value,
	// and an ascending full set, the slowest case
	task automatic test_store_overflow();
		int k;
		for (k = 0; k < MAX_ELEMENTS + 2; k++) begin
			send_item(rand_value(), k == MAX_ELEMENTS + 1);
		end
		for (k = 0; k < MAX_ELEMENTS; k++) begin
			send_item(32'(k * 3 - 90), k == MAX_ELEMENTS - 1);
		end
	endtask

	// random sets, mostly small, with changing idle patterns
	task automatic test_random_sets();
		int set_len;
		int r;
		int k;
		while (values_stored < ITEM_TARGET) begin
			src_idle_en  = ($urandom_range(0, 3) != 0);
			snk_stall_en = ($urandom_range(0, 3) != 0);
			r = $urandom_range(0, 9);
			if (r < 6) begin
				set_len = $urandom_range(1, 8);
			end else if (r < 9) begin
				set_len = $urandom_range(9, 24);
			end else begin
				set_len = $urandom_range(25, 48);
			end
			for (k = 0; k < set_len; k++) begin
				send_item(rand_value(), k == set_len - 1);
			end
			if ($urandom_range(0, 5) == 0) begin
				wait_drained();
			end
		end
	endtask

	// test sequence
	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		m_axis_tready = 1'b0;
		stall_left    = 0;
		src_idle_en   = 1'b1;
		snk_stall_en  = 1'b1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_lone_value();
		test_field_extremes();
		test_ordered_inputs();
		wait_drained();
		test_store_overflow();
		test_random_sets();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		mismatches += owed_words.size();

		$display("covered %0d sorted runs from %0d stored values, %0d over-capacity values dropped",
			runs_closed, values_stored, values_dropped);
		$display("%0d sorted words checked, %0d failures", words_checked, mismatches);
		if (mismatches == 0) begin
			$display("tb_quicksort_first_pivot: PASS");
		end else begin
			$display("tb_quicksort_first_pivot: FAIL");
		end
		$finish;
	end

endmodule
